// ----- hw/rtl/qxmm_pkg.sv -----
// Shared types and constants of the quadcopter X-frame motor mixer.
`timescale 1ns / 1ps

package qxmm_pkg;

	localparam int NumMotors = 4;

	// Register map of the configuration port.
	typedef enum logic [2:0] {
		REG_GAIN           = 3'd0,
		REG_UPPER_DEADBAND = 3'd1,
		REG_LOWER_DEADBAND = 3'd2,
		REG_WIDTH_MIN      = 3'd3,
		REG_WIDTH_MAX      = 3'd4
	} reg_index_t;

	// Motor order is front left, front right, rear left, rear right (bit 0 to bit 3).
	// A set bit means the term is subtracted for that motor.
	localparam logic [NumMotors-1:0] YawNeg   = 4'b0110;
	localparam logic [NumMotors-1:0] PitchNeg = 4'b1100;
	localparam logic [NumMotors-1:0] RollNeg  = 4'b1010;

	localparam logic [15:0] GainReset     = 16'd256;
	localparam logic [15:0] WidthMaxReset = 16'hFFFF;

	typedef struct packed {
		logic signed [15:0] yaw_error;
		logic signed [15:0] pitch_error;
		logic signed [15:0] roll_error;
	} attitude_t;

	typedef struct packed {
		logic [15:0] front_left_width;
		logic [15:0] front_right_width;
		logic [15:0] rear_left_width;
		logic [15:0] rear_right_width;
	} motor_t;

	typedef struct packed {
		logic [2:0]  reg_index;
		logic [15:0] wdata;
	} cfg_write_t;

	typedef struct packed {
		logic        [15:0] gain;
		logic signed [15:0] upper_deadband;
		logic signed [15:0] lower_deadband;
		logic        [15:0] width_min;
		logic        [15:0] width_max;
	} cfg_regs_t;

	// Scaled Q16.16 error terms; gain times a 16-bit error always fits 32 signed bits.
	typedef logic signed [31:0] prod_t;

	typedef struct packed {
		prod_t yaw;
		prod_t pitch;
		prod_t roll;
	} mix_terms_t;

endpackage

// ----- hw/rtl/qxmm_stream_if.sv -----
// Valid/ready stream interface used for every channel of the mixer.
`timescale 1ns / 1ps

interface qxmm_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/qxmm_fifo.sv -----
// Small queue between the classify/multiply front and the mixing back end.
`timescale 1ns / 1ps

module qxmm_fifo #(
	parameter int  DEPTH = 2,
	parameter type T     = logic
) (
	input  logic          clk,
	input  logic          arst_n,
	qxmm_stream_if.sink   wr,
	qxmm_stream_if.source rd
);
	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign wr.ready = (count_q != CntW'(DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.data  = mem_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

endmodule

// ----- hw/rtl/qxmm_front.sv -----
// Front end: deadband classification and gain scaling of the three attitude errors.
`timescale 1ns / 1ps

module qxmm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  qxmm_pkg::cfg_regs_t cfg_regs,
	qxmm_stream_if.sink         attitude,
	qxmm_stream_if.source       terms
);
	logic                   valid_s1;
	qxmm_pkg::mix_terms_t   terms_s1;
	logic                   load;

	// An error counts when it lies strictly outside either deadband edge.
	function automatic qxmm_pkg::prod_t scale(input logic signed [15:0] err,
			input qxmm_pkg::cfg_regs_t c);
		logic               counts;
		logic signed [32:0] prod;
		counts = ($signed(err) > $signed(c.upper_deadband)) ||
			($signed(err) < $signed(c.lower_deadband));
		prod = $signed({1'b0, c.gain}) * $signed(err);
		return counts ? $signed(prod[31:0]) : '0;
	endfunction

	assign attitude.ready = !valid_s1 || terms.ready;
	assign load           = attitude.valid && attitude.ready;
	assign terms.valid    = valid_s1;
	assign terms.data     = terms_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (attitude.ready) begin
			valid_s1 <= attitude.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			terms_s1.yaw   <= scale(attitude.data.yaw_error, cfg_regs);
			terms_s1.pitch <= scale(attitude.data.pitch_error, cfg_regs);
			terms_s1.roll  <= scale(attitude.data.roll_error, cfg_regs);
		end
	end

endmodule

// ----- hw/rtl/qxmm_back.sv -----
// Back end: X-frame mixing, correction saturation and the motor width update.
`timescale 1ns / 1ps

module qxmm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  qxmm_pkg::cfg_regs_t cfg_regs,
	qxmm_stream_if.sink         terms,
	qxmm_stream_if.source       motor
);
	localparam int NumMotors = qxmm_pkg::NumMotors;

	logic               valid_s1;
	logic signed [15:0] corr_s1 [NumMotors];
	logic [15:0]        widths_q [NumMotors];
	logic               out_valid_q;
	logic               adv_s1;
	logic               adv_s2;

	// Signed sum of the three terms, truncated toward zero to whole counts
	// and saturated to 16 signed bits.
	function automatic logic signed [15:0] correction(input qxmm_pkg::mix_terms_t t,
			input int m);
		logic signed [33:0] ty;
		logic signed [33:0] tp;
		logic signed [33:0] tr;
		logic signed [33:0] sum;
		logic signed [33:0] biased;
		logic signed [17:0] q;
		ty = 34'(t.yaw);
		tp = 34'(t.pitch);
		tr = 34'(t.roll);
		if (qxmm_pkg::YawNeg[m]) begin
			ty = -ty;
		end
		if (qxmm_pkg::PitchNeg[m]) begin
			tp = -tp;
		end
		if (qxmm_pkg::RollNeg[m]) begin
			tr = -tr;
		end
		sum    = ty + tp + tr;
		biased = sum + (sum[33] ? 34'sd65535 : 34'sd0);
		q      = biased[33:16];
		if (q > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (q < -18'sd32768) begin
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	function automatic logic [15:0] update(input logic [15:0] w,
			input logic signed [15:0] c, input qxmm_pkg::cfg_regs_t r);
		logic signed [17:0] total;
		total = $signed({2'b00, w}) + 18'(c);
		if (total > $signed({2'b00, r.width_max})) begin
			return r.width_max;
		end else if (total < $signed({2'b00, r.width_min})) begin
			return r.width_min;
		end
		return total[15:0];
	endfunction

	assign adv_s2      = !out_valid_q || motor.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign terms.ready = adv_s1;

	assign motor.valid                  = out_valid_q;
	assign motor.data.front_left_width  = widths_q[0];
	assign motor.data.front_right_width = widths_q[1];
	assign motor.data.rear_left_width   = widths_q[2];
	assign motor.data.rear_right_width  = widths_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= terms.valid;
			end
			if (adv_s2) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && terms.valid) begin
			for (int m = 0; m < NumMotors; m++) begin
				corr_s1[m] <= correction(terms.data, m);
			end
		end
	end

	// The stored widths are the motor state; they move only when a new
	// result enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < NumMotors; m++) begin
				widths_q[m] <= '0;
			end
		end else if (adv_s2 && valid_s1) begin
			for (int m = 0; m < NumMotors; m++) begin
				widths_q[m] <= update(widths_q[m], corr_s1[m], cfg_regs);
			end
		end
	end

endmodule

// ----- hw/rtl/quad_x_motor_mixer.sv -----
// Path of an accepted attitude transaction: the front multiplier register, the queue,
// the mixing register and the output register, in that order. Throughput: one
// transaction per cycle while the motor side accepts motor transactions.
// The width feedback loop is the output register alone, so items follow back to back.
// Reset: gain 1.0, deadbands zero, width bounds 0 and 65535, widths zero, queue empty.
`timescale 1ns / 1ps

module quad_x_motor_mixer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	qxmm_stream_if.sink   attitude,
	qxmm_stream_if.source motor,
	qxmm_stream_if.sink   cfg
);
	qxmm_pkg::cfg_regs_t cfg_q;

	qxmm_stream_if #(.T(qxmm_pkg::mix_terms_t)) front_link ();
	qxmm_stream_if #(.T(qxmm_pkg::mix_terms_t)) queue_link ();

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain           <= qxmm_pkg::GainReset;
			cfg_q.upper_deadband <= '0;
			cfg_q.lower_deadband <= '0;
			cfg_q.width_min      <= '0;
			cfg_q.width_max      <= qxmm_pkg::WidthMaxReset;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.reg_index)
				qxmm_pkg::REG_GAIN: begin
					cfg_q.gain <= cfg.data.wdata;
				end
				qxmm_pkg::REG_UPPER_DEADBAND: begin
					cfg_q.upper_deadband <= $signed(cfg.data.wdata);
				end
				qxmm_pkg::REG_LOWER_DEADBAND: begin
					cfg_q.lower_deadband <= $signed(cfg.data.wdata);
				end
				qxmm_pkg::REG_WIDTH_MIN: begin
					cfg_q.width_min <= cfg.data.wdata;
				end
				qxmm_pkg::REG_WIDTH_MAX: begin
					cfg_q.width_max <= cfg.data.wdata;
				end
				default: begin
				end
			endcase
		end
	end

	qxmm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_q),
		.attitude (attitude),
		.terms    (front_link)
	);

	qxmm_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.T     (qxmm_pkg::mix_terms_t)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_link),
		.rd     (queue_link)
	);

	qxmm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_q),
		.terms    (queue_link),
		.motor    (motor)
	);

	// An accepted attitude transaction always lands in the front register.
	a_front_load: assert property (@(posedge clk) disable iff (!arst_n)
		attitude.valid && attitude.ready |=> front_link.valid)
		else $error("accepted attitude transaction lost in front end");

	// Scaled terms wait unchanged when the queue is full.
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		front_link.valid && !front_link.ready |=>
			front_link.valid && $stable(front_link.data))
		else $error("front end dropped or changed stalled terms");

	// The motor state must not advance while a result is still waiting.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		motor.valid && !motor.ready |=> motor.valid && $stable(motor.data))
		else $error("motor widths changed while result stalled");

endmodule

// ----- bench/quad_x_motor_mixer_test.sv -----
// Self-checking testbench of the X-frame motor mixer, with a scoreboard class and stream drivers.
`timescale 1ns / 1ps

module quad_x_motor_mixer_test;

	localparam int DrainCycles = 8;
	localparam logic [2:0] FirstUnusedReg = 3'd5;
	localparam logic [2:0] LastUnusedReg = 3'd7;

	// Tracks the configuration and motor widths, and predicts each motor transaction.
	class mixer_scoreboard;
		logic        [15:0] gain;
		logic signed [15:0] upper_db;
		logic signed [15:0] lower_db;
		logic        [15:0] wmin;
		logic        [15:0] wmax;
		logic        [15:0] widths [qxmm_pkg::NumMotors];
		qxmm_pkg::motor_t   expected_widths [$];
		int                 mismatches;

		function new();
			gain = qxmm_pkg::GainReset;
			upper_db = '0;
			lower_db = '0;
			wmin = '0;
			wmax = qxmm_pkg::WidthMaxReset;
			foreach (widths[m]) widths[m] = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] value);
			case (idx)
				qxmm_pkg::REG_GAIN: gain = value;
				qxmm_pkg::REG_UPPER_DEADBAND: upper_db = value;
				qxmm_pkg::REG_LOWER_DEADBAND: lower_db = value;
				qxmm_pkg::REG_WIDTH_MIN: wmin = value;
				qxmm_pkg::REG_WIDTH_MAX: wmax = value;
				default: ;
			endcase
		endfunction

		function longint scaled_error(logic signed [15:0] e);
			longint g;
			longint ev;
			g = gain;
			ev = e;
			if (e > upper_db || e < lower_db)
				return g * ev;
			return 0;
		endfunction

		function qxmm_pkg::motor_t mix_widths(qxmm_pkg::attitude_t a);
			longint py, pp, pr, sum, corr, total, lo, hi;
			qxmm_pkg::motor_t r;
			py = scaled_error(a.yaw_error);
			pp = scaled_error(a.pitch_error);
			pr = scaled_error(a.roll_error);
			lo = wmin;
			hi = wmax;
			for (int m = 0; m < qxmm_pkg::NumMotors; m++) begin
				sum = (qxmm_pkg::YawNeg[m] ? -py : py) + (qxmm_pkg::PitchNeg[m] ? -pp : pp)
					+ (qxmm_pkg::RollNeg[m] ? -pr : pr);
				// Integer division of longint truncates toward zero.
				corr = sum / 65536;
				if (corr > 32767)
					corr = 32767;
				else if (corr < -32768)
					corr = -32768;
				total = widths[m];
				total = total + corr;
				if (total > hi)
					total = hi;
				else if (total < lo)
					total = lo;
				widths[m] = total[15:0];
			end
			r.front_left_width = widths[0];
			r.front_right_width = widths[1];
			r.rear_left_width = widths[2];
			r.rear_right_width = widths[3];
			return r;
		endfunction

		function void note_attitude(qxmm_pkg::attitude_t a);
			expected_widths.push_back(mix_widths(a));
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_motor(qxmm_pkg::motor_t got);
			qxmm_pkg::motor_t want;
			if (expected_widths.size() == 0) begin
				report($sformatf("motor transaction %h with nothing expected", got));
				return;
			end
			want = expected_widths.pop_front();
			if (got.front_left_width !== want.front_left_width)
				report($sformatf("front left width %0d, expected %0d",
					got.front_left_width, want.front_left_width));
			if (got.front_right_width !== want.front_right_width)
				report($sformatf("front right width %0d, expected %0d",
					got.front_right_width, want.front_right_width));
			if (got.rear_left_width !== want.rear_left_width)
				report($sformatf("rear left width %0d, expected %0d",
					got.rear_left_width, want.rear_left_width));
			if (got.rear_right_width !== want.rear_right_width)
				report($sformatf("rear right width %0d, expected %0d",
					got.rear_right_width, want.rear_right_width));
		endtask
	endclass

	logic clk;
	logic arst_n;

	qxmm_stream_if #(.T(qxmm_pkg::attitude_t))  attitude_ch ();
	qxmm_stream_if #(.T(qxmm_pkg::motor_t))     motor_ch ();
	qxmm_stream_if #(.T(qxmm_pkg::cfg_write_t)) cfg_ch ();

	quad_x_motor_mixer uut (
		.clk(clk),
		.arst_n(arst_n),
		.attitude(attitude_ch),
		.motor(motor_ch),
		.cfg(cfg_ch)
	);

	mixer_scoreboard sb;
	bit sender_idles;
	bit receiver_idles;
	int hold_request;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAIL quad_x_motor_mixer");
		$finish;
	end

	function automatic qxmm_pkg::attitude_t att(int y, int p, int r);
		qxmm_pkg::attitude_t a;
		a.yaw_error = 16'(y);
		a.pitch_error = 16'(p);
		a.roll_error = 16'(r);
		return a;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with valid still high.
	task automatic send_attitude(qxmm_pkg::attitude_t a);
		int gap;
		gap = sender_idles ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			attitude_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		attitude_ch.data = a;
		attitude_ch.valid = 1'b1;
		do @(posedge clk); while (!attitude_ch.ready);
		sb.note_attitude(a);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		cfg_ch.data = '{reg_index: idx, wdata: value};
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic drain();
		attitude_ch.valid = 1'b0;
		while (sb.expected_widths.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	function automatic logic [15:0] random_error();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 4096) - 2048);
			1: begin
				case ($urandom_range(0, 2))
					0: return 16'h7FFF;
					1: return 16'h8000;
					default: return 16'h0000;
				endcase
			end
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] random_deadband();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			default: return 16'($urandom_range(0, 2048) - 1024);
		endcase
	endfunction

	task automatic random_config();
		logic [15:0] g, a, b, lo, hi;
		case ($urandom_range(0, 5))
			0: g = 16'h0000;
			1: g = 16'hFFFF;
			2: g = qxmm_pkg::GainReset;
			3: g = 16'($urandom_range(0, 1024));
			default: g = 16'($urandom_range(0, 65535));
		endcase
		a = 16'($urandom_range(0, 65535));
		b = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 4))
			0: begin
				lo = 16'h0000;
				hi = 16'hFFFF;
			end
			1: begin
				// Crossed bounds: minimum above maximum.
				lo = 16'($urandom_range(1000, 65535));
				hi = 16'($urandom_range(0, lo - 1));
			end
			default: begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
		endcase
		if ($urandom_range(0, 3) == 0)
			write_reg(3'($urandom_range(FirstUnusedReg, LastUnusedReg)),
				16'($urandom_range(0, 65535)));
		write_reg(qxmm_pkg::REG_GAIN, g);
		write_reg(qxmm_pkg::REG_UPPER_DEADBAND, random_deadband());
		write_reg(qxmm_pkg::REG_LOWER_DEADBAND, random_deadband());
		write_reg(qxmm_pkg::REG_WIDTH_MIN, lo);
		write_reg(qxmm_pkg::REG_WIDTH_MAX, hi);
	endtask

	// Motor side: random stalls per transaction, plus a long hold when one is requested.
	initial begin
		int stall;
		motor_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				motor_ch.ready = 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			stall = receiver_idles ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				motor_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			motor_ch.ready = 1'b1;
			do @(posedge clk); while (!motor_ch.valid);
			sb.check_motor(motor_ch.data);
		end
	end

	initial begin
		sb = new();
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		hold_request = 0;
		attitude_ch.valid = 1'b0;
		attitude_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset configuration: field extremes and mixed signs.
		send_attitude(att(0, 0, 0));
		send_attitude(att(32767, 0, 0));
		send_attitude(att(0, 32767, 0));
		send_attitude(att(0, 0, 32767));
		send_attitude(att(-32768, -32768, -32768));
		send_attitude(att(1, -1, 256));
		send_attitude(att(-256, 512, -768));
		drain();

		// Largest gain: the summed correction saturates before it is added.
		write_reg(qxmm_pkg::REG_GAIN, 16'hFFFF);
		send_attitude(att(32767, 32767, 32767));
		send_attitude(att(-32768, -32768, -32768));
		send_attitude(att(-32768, 32767, -32768));
		drain();

		// Overlapping deadbands: every error is used.
		write_reg(qxmm_pkg::REG_GAIN, 16'd128);
		write_reg(qxmm_pkg::REG_UPPER_DEADBAND, -16'sd512);
		write_reg(qxmm_pkg::REG_LOWER_DEADBAND, 16'sd512);
		send_attitude(att(0, 0, 0));
		send_attitude(att(100, -100, 300));
		send_attitude(att(-600, 600, 1));
		drain();

		// Crossed width bounds.
		write_reg(qxmm_pkg::REG_GAIN, qxmm_pkg::GainReset);
		write_reg(qxmm_pkg::REG_WIDTH_MIN, 16'd40000);
		write_reg(qxmm_pkg::REG_WIDTH_MAX, 16'd1000);
		send_attitude(att(1000, 0, 0));
		send_attitude(att(-32768, 0, 0));
		send_attitude(att(0, 0, 0));
		drain();

		// Unused register indexes must change nothing; then deadbands that reject everything.
		for (int i = FirstUnusedReg; i <= LastUnusedReg; i++)
			write_reg(3'(i), 16'h0000);
		write_reg(qxmm_pkg::REG_WIDTH_MIN, 16'h0000);
		write_reg(qxmm_pkg::REG_WIDTH_MAX, 16'hFFFF);
		write_reg(qxmm_pkg::REG_UPPER_DEADBAND, 16'h7FFF);
		write_reg(qxmm_pkg::REG_LOWER_DEADBAND, 16'h8000);
		send_attitude(att(32767, -32768, 1200));
		send_attitude(att(-1, 2, 3));
		drain();
		write_reg(qxmm_pkg::REG_GAIN, 16'h0000);
		write_reg(qxmm_pkg::REG_UPPER_DEADBAND, 16'h0000);
		write_reg(qxmm_pkg::REG_LOWER_DEADBAND, 16'h0000);
		send_attitude(att(-32768, 32767, -5));
		drain();

		for (int phase = 0; phase < 11; phase++) begin
			random_config();
			sender_idles = (phase % 4 == 0) || (phase % 4 == 2);
			receiver_idles = (phase % 4 == 0) || (phase % 4 == 1);
			if (phase == 5) begin
				// The motor side holds off long enough for the block to back up.
				sender_idles = 1'b0;
				hold_request = 120;
			end
			for (int n = 0; n < 100; n++) begin
				if (phase == 5 && n == 40)
					sender_idles = 1'b1;
				send_attitude(att(random_error(), random_error(), random_error()));
			end
			drain();
		end

		if (sb.mismatches == 0)
			$display("PASS quad_x_motor_mixer");
		else
			$display("FAIL quad_x_motor_mixer");
		$finish;
	end

endmodule
